### rtl/bpfa_pkg.sv
// shared constants and types for the bitmap page frame allocator
`default_nettype none

package bpfa_pkg;

  localparam int MAX_PAGES_DEF  = 65536;
  localparam int PAGE_SHIFT_DEF = 12;

  localparam int WORD_W  = 32;
  localparam int ADDR_W  = 32;
  localparam int CFG_W   = 17;
  localparam int KS_W    = 16;
  localparam int LIM_W   = 18;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [CFG_W-1:0] TOTAL_RST  = 17'd65536;
  localparam logic [CFG_W-1:0] LOWRES_RST = 17'd256;
  localparam logic [KS_W-1:0]  KSTART_RST = 16'd256;
  localparam logic [CFG_W-1:0] KPAGES_RST = 17'd0;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_PAGE      = 2'd1,
    ST_RANGE        = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_TOTAL  = 2'd0,
    REG_LOWRES = 2'd1,
    REG_KSTART = 2'd2,
    REG_KPAGES = 2'd3
  } reg_index_t;

endpackage

`default_nettype wire

### rtl/bpfa_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module bpfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/bitmap_page_frame_allocator_unit.sv
// bitmap page frame allocator: first-fit search over a word-wide page map in ram
// free reads the addressed map word, then clears the page's bit if set; out-of-range free and
// unused opcode finish without the map; allocate reads from word 0 up to the word holding
// the page found, initialize writes every word; the map ram is walked one word per cycle.
// one command at a time: busy stays high until the command finishes; done is a one-cycle strobe.
// after reset the map ram is cleared one word per cycle, busy high until all words are cleared.
`default_nettype none

module bitmap_page_frame_allocator_unit
  import bpfa_pkg::*;
#(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         opcode,
  input  wire logic [ADDR_W-1:0]  page_address,
  output logic                    done,
  output logic [1:0]              status,
  output logic [ADDR_W-1:0]       alloc_address,
  output logic [CFG_W-1:0]        free_pages,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  localparam int MAP_WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int AW        = $clog2(MAP_WORDS);
  localparam int MPW       = $clog2(MAX_PAGES + 1);
  localparam int EW        = (MPW > CFG_W) ? MPW : CFG_W;
  localparam int CW        = ((AW + 5) > (LIM_W + 1)) ? (AW + 5) : (LIM_W + 1);
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_INIT  = 6'b000100,
    S_ALLOC = 6'b001000,
    S_FREE  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  logic [CFG_W-1:0] page_limit;
  logic [CFG_W-1:0] low_reserved_pages;
  logic [KS_W-1:0]  kernel_start_page;
  logic [CFG_W-1:0] kern_span;

  logic [CFG_W-1:0]  used_count;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     rd_w;
  logic [CFG_W-1:0]  page_r;
  status_t           st_r;
  logic [ADDR_W-1:0] addr_r;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [CFG_W-1:0]  t_eff;
  logic [CFG_W-1:0]  free_calc;
  logic [CFG_W-1:0]  lo_lim;
  logic [LIM_W-1:0]  kend_raw;
  logic [LIM_W-1:0]  kend_lim;
  logic [WORD_W-1:0] init_mask;
  logic [ADDR_W-1:0] req_page;
  logic              req_range;
  logic              accept;
  logic              cfg_wr;

  logic              zero_hit;
  logic [4:0]        zero_bit;
  logic [CW-1:0]     base_c;
  logic [CW-1:0]     found_c;
  logic [CW-1:0]     t_c;
  logic              alloc_past;
  logic              alloc_hit;
  logic              alloc_end;
  logic [ADDR_W-1:0] found_addr;
  logic              free_bit;

  // mask of bits in word w whose page number is below lim
  function automatic logic [WORD_W-1:0] lt_mask(input logic [AW-1:0] w,
                                                 input logic [LIM_W-1:0] lim);
    logic [CW-1:0] wc;
    logic [CW-1:0] lc;
    wc = CW'(w);
    lc = CW'(lim >> 5);
    if (wc < lc) begin
      lt_mask = '1;
    end else if (wc == lc) begin
      lt_mask = (WORD_W'(1) << lim[4:0]) - WORD_W'(1);
    end else begin
      lt_mask = '0;
    end
  endfunction

  bpfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_limit         <= TOTAL_RST;
      low_reserved_pages <= LOWRES_RST;
      kernel_start_page  <= KSTART_RST;
      kern_span          <= KPAGES_RST;
    end else if (cfg_wr) begin
      case (reg_index_t'(paddr[3:2]))
        REG_TOTAL:  page_limit         <= pwdata[CFG_W-1:0];
        REG_LOWRES: low_reserved_pages <= pwdata[CFG_W-1:0];
        REG_KSTART: kernel_start_page  <= pwdata[KS_W-1:0];
        REG_KPAGES: kern_span          <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[3:2]))
      REG_TOTAL:  prdata = PDATA_W'(page_limit);
      REG_LOWRES: prdata = PDATA_W'(low_reserved_pages);
      REG_KSTART: prdata = PDATA_W'(kernel_start_page);
      REG_KPAGES: prdata = PDATA_W'(kern_span);
      default:    prdata = '0;
    endcase
  end

  // effective total and reserved limits
  always_comb begin
    if (EW'(page_limit) > EW'(MAX_PAGES)) begin
      t_eff = CFG_W'(MAX_PAGES);
    end else begin
      t_eff = page_limit;
    end
    free_calc = (t_eff > used_count) ? (t_eff - used_count) : '0;
    lo_lim    = (low_reserved_pages < t_eff) ? low_reserved_pages : t_eff;
    kend_raw  = LIM_W'(kernel_start_page) + LIM_W'(kern_span);
    kend_lim  = (kend_raw > LIM_W'(t_eff)) ? LIM_W'(t_eff) : kend_raw;
    init_mask = lt_mask(idx, LIM_W'(lo_lim))
              | (lt_mask(idx, kend_lim) & ~lt_mask(idx, LIM_W'(kernel_start_page)));
  end

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign req_page  = page_address >> PAGE_SHIFT;
  assign req_range = (req_page >= ADDR_W'(t_eff));

  // lowest clear bit of the word read back
  always_comb begin
    zero_hit = 1'b0;
    zero_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!ram_rdata[i]) begin
        zero_hit = 1'b1;
        zero_bit = 5'(i);
      end
    end
  end

  always_comb begin
    t_c        = CW'(t_eff);
    base_c     = CW'({rd_w, 5'b0});
    found_c    = CW'({rd_w, zero_bit});
    alloc_past = (base_c >= t_c);
    alloc_hit  = !alloc_past && zero_hit && (found_c < t_c);
    alloc_end  = alloc_past || zero_hit || (rd_w == LAST_WORD);
    found_addr = ADDR_W'({rd_w, zero_bit}) << PAGE_SHIFT;
    free_bit   = ram_rdata[page_r[4:0]];
  end

  // map ram access
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    ram_raddr = idx;
    case (state)
      S_IDLE: begin
        ram_raddr = (opcode_t'(opcode) == OP_FREE) ? AW'(req_page >> 5) : '0;
      end
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = init_mask;
      end
      S_ALLOC: begin
        ram_we    = alloc_hit;
        ram_waddr = rd_w;
        ram_wdata = ram_rdata | (WORD_W'(1) << zero_bit);
      end
      S_FREE: begin
        ram_we    = free_bit;
        ram_waddr = AW'(page_r >> 5);
        ram_wdata = ram_rdata & ~(WORD_W'(1) << page_r[4:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      idx        <= '0;
      used_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            st_r   <= ST_OK;
            addr_r <= '0;
            rd_w   <= '0;
            case (opcode_t'(opcode))
              OP_ALLOC: begin
                idx   <= AW'(1);
                state <= S_ALLOC;
              end
              OP_FREE: begin
                page_r <= CFG_W'(req_page);
                if (req_range) begin
                  st_r  <= ST_RANGE;
                  state <= S_DONE;
                end else begin
                  state <= S_FREE;
                end
              end
              OP_INIT: begin
                idx        <= '0;
                used_count <= '0;
                state      <= S_INIT;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_CLEAR: begin
          idx <= idx + AW'(1);
          if (idx == LAST_WORD) begin
            state <= S_IDLE;
          end
        end
        S_INIT: begin
          used_count <= used_count + CFG_W'($countones(init_mask));
          idx        <= idx + AW'(1);
          if (idx == LAST_WORD) begin
            state <= S_DONE;
          end
        end
        S_ALLOC: begin
          rd_w <= idx;
          if (idx != LAST_WORD) begin
            idx <= idx + AW'(1);
          end
          if (alloc_hit) begin
            used_count <= used_count + CFG_W'(1);
            addr_r     <= found_addr;
            state      <= S_DONE;
          end else if (alloc_end) begin
            st_r  <= ST_NO_PAGE;
            state <= S_DONE;
          end
        end
        S_FREE: begin
          if (!free_bit) begin
            st_r <= ST_ALREADY_FREE;
          end else if (used_count != '0) begin
            used_count <= used_count - CFG_W'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      status        <= st_r;
      alloc_address <= addr_r;
      free_pages    <= free_calc;
    end
  end

`ifndef ASSERT_OFF
  a_done_follows_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> done)
    else $error("result strobe missing after command finish");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> busy)
    else $error("block not busy during map clearing pass");

  a_no_page_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_NO_PAGE)) |-> (alloc_address == '0))
    else $error("nonzero address reported with no free page");

  a_write_only_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> busy)
    else $error("map write while idle");

  a_free_within_total: assert property (@(posedge clk) disable iff (rst)
    done |-> (free_pages <= t_eff))
    else $error("free count above page total");
`endif

endmodule

`default_nettype wire
